// ===== hdl/smpd_pkg.sv =====
// Shared codes, widths and the queue entry type of the signal mask dispatch block.
package smpd_pkg;

   localparam int MASK_W      = 32;
   localparam int NUM_SIG_DEF = 32;

   localparam logic [2:0] KIND_RAISE    = 3'd0;
   localparam logic [2:0] KIND_KILL     = 3'd1;
   localparam logic [2:0] KIND_BLOCK    = 3'd2;
   localparam logic [2:0] KIND_UNBLOCK  = 3'd3;
   localparam logic [2:0] KIND_SETMASK  = 3'd4;
   localparam logic [2:0] KIND_SETDISP  = 3'd5;
   localparam logic [2:0] KIND_QUERY    = 3'd6;

   localparam logic [1:0] DISP_DEFAULT  = 2'd0;
   localparam logic [1:0] DISP_IGNORE   = 2'd1;
   localparam logic [1:0] DISP_HANDLER  = 2'd2;

   localparam logic [1:0] ACT_STATUS    = 2'd0;
   localparam logic [1:0] ACT_HANDLER   = 2'd1;
   localparam logic [1:0] ACT_ABORT     = 2'd2;

   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_INVALID  = 2'd1;
   localparam logic [1:0] STAT_NO_PROC  = 2'd2;

   localparam logic [4:0] ABORT_RESET   = 5'd6;

   // One classified item: the handler deliveries still to be emitted, the
   // abort decision and the fields shared by all results of the item.
   typedef struct packed {
      logic [MASK_W-1:0] hand;
      logic              abort_hit;
      logic [5:0]        abort_sig;
      logic [1:0]        old_disp;
      logic [MASK_W-1:0] old_mask;
      logic [MASK_W-1:0] pending;
      logic [1:0]        status;
   } item_type;

endpackage

// ===== hdl/smpd_front.sv =====
// Front part: holds masks and dispositions and classifies each accepted item.
module smpd_front #(
   parameter int NUM_SIGNALS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [2:0]        kind,
   input  logic [5:0]        signal_number,
   input  logic              target_is_self,
   input  logic [31:0]       mask_value,
   input  logic [1:0]        disposition,
   input  logic              csr_write,
   input  logic [4:0]        csr_abort_signal,
   output smpd_pkg::item_type item
);
   import smpd_pkg::*;

   localparam int SigLimit = (NUM_SIGNALS < MASK_W) ? NUM_SIGNALS : MASK_W;
   localparam int IdxW = $clog2(SigLimit);
   localparam logic [MASK_W-1:0] ValidMask =
      ((SigLimit == MASK_W) ? {MASK_W{1'b1}} : ((MASK_W'(1) << SigLimit) - MASK_W'(1)))
      & ~MASK_W'(1);

   logic [1:0]        disp_ff [SigLimit];
   logic [MASK_W-1:0] blocked_ff, blocked_in;
   logic [MASK_W-1:0] pending_ff, pending_in;
   logic [4:0]        abort_ff, abort_in;
   logic              disp_we;

   logic [MASK_W-1:0] hand_vec, def_vec;
   logic [MASK_W-1:0] sig_bit, abort_bit, low_mask;
   logic [MASK_W-1:0] cand, abort_cand, cleared;
   logic [IdxW-1:0]   sig_idx;
   logic              sig_ok;

   for (genvar i = 0; i < MASK_W; i++) begin : g_vec
      if (i >= 1 && i < SigLimit) begin : g_on
         assign hand_vec[i] = (disp_ff[i] == DISP_HANDLER);
         assign def_vec[i]  = (disp_ff[i] == DISP_DEFAULT);
      end else begin : g_off
         assign hand_vec[i] = 1'b0;
         assign def_vec[i]  = 1'b0;
      end
   end

   assign sig_idx   = signal_number[IdxW-1:0];
   assign sig_ok    = (signal_number != 6'd0) && ({1'b0, signal_number} < 7'(SigLimit));
   assign sig_bit   = MASK_W'(1) << signal_number[4:0];
   assign abort_bit = MASK_W'(1) << abort_ff;
   assign low_mask  = (abort_bit - MASK_W'(1)) | abort_bit;
   assign abort_in  = csr_write ? csr_abort_signal : abort_ff;

   always_comb begin
      blocked_in     = blocked_ff;
      pending_in     = pending_ff;
      disp_we        = 1'b0;
      cand           = '0;
      abort_cand     = '0;
      cleared        = '0;
      item.hand      = '0;
      item.abort_hit = 1'b0;
      item.abort_sig = {1'b0, abort_ff};
      item.old_disp  = DISP_DEFAULT;
      item.old_mask  = '0;
      item.status    = STAT_OK;
      case (kind)
         KIND_RAISE, KIND_KILL: begin
            if (kind == KIND_KILL && !target_is_self) begin
               item.status = STAT_NO_PROC;
            end else if (kind == KIND_KILL && signal_number == 6'd0) begin
               item.status = STAT_OK;
            end else if (!sig_ok) begin
               item.status = STAT_INVALID;
            end else if ((blocked_ff & sig_bit) != '0) begin
               pending_in = pending_ff | sig_bit;
            end else begin
               item.hand      = sig_bit & hand_vec;
               item.abort_hit = ((sig_bit & def_vec & abort_bit) != '0);
            end
         end
         KIND_BLOCK, KIND_UNBLOCK, KIND_SETMASK: begin
            item.old_mask = blocked_ff;
            if (kind == KIND_BLOCK) begin
               blocked_in = blocked_ff | mask_value;
            end else if (kind == KIND_UNBLOCK) begin
               blocked_in = blocked_ff & ~mask_value;
            end else begin
               blocked_in = mask_value;
            end
            // The sweep clears every ready bit, but stops at a default abort signal.
            cand       = pending_ff & ~blocked_in & ValidMask;
            abort_cand = cand & def_vec & abort_bit;
            cleared    = (abort_cand != '0) ? (cand & low_mask) : cand;
            pending_in = pending_ff & ~cleared;
            item.hand      = cleared & hand_vec;
            item.abort_hit = (abort_cand != '0);
         end
         KIND_SETDISP: begin
            if (!sig_ok) begin
               item.status = STAT_INVALID;
            end else begin
               item.old_disp = disp_ff[sig_idx];
               if (disposition > DISP_HANDLER) begin
                  item.status = STAT_INVALID;
               end else begin
                  disp_we = 1'b1;
               end
            end
         end
         KIND_QUERY: begin
            item.old_mask = blocked_ff;
         end
         default: begin
            item.status = STAT_INVALID;
         end
      endcase
      item.pending = pending_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blocked_ff <= '0;
         pending_ff <= '0;
         abort_ff   <= ABORT_RESET;
         for (int i = 0; i < SigLimit; i++) begin
            disp_ff[i] <= DISP_DEFAULT;
         end
      end else begin
         abort_ff <= abort_in;
         if (accept) begin
            blocked_ff <= blocked_in;
            pending_ff <= pending_in;
            if (disp_we) begin
               disp_ff[sig_idx] <= disposition;
            end
         end
      end
   end

endmodule

// ===== hdl/smpd_queue.sv =====
// Two-entry queue of classified items between the front and back parts.
module smpd_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  smpd_pkg::item_type push_item,
   output logic               can_push,
   input  logic               pop,
   output logic               head_valid,
   output smpd_pkg::item_type head_item
);
   import smpd_pkg::*;

   item_type   slot0_ff, slot0_in;
   item_type   slot1_ff, slot1_in;
   logic [1:0] count_ff, count_in;

   assign can_push   = (count_ff != 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_item  = slot0_ff;

   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      count_in = count_ff;
      if (pop) begin
         slot0_in = slot1_ff;
      end
      if (push) begin
         // The new item lands behind whatever remains after the pop.
         if ((count_ff == 2'd0) || (count_ff == 2'd1 && pop)) begin
            slot0_in = push_item;
         end else begin
            slot1_in = push_item;
         end
      end
      count_in = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("queue count out of range");

   a_pop_only: assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> (count_ff == $past(count_ff) - 2'd1))
      else $error("queue count did not drop after pop");

endmodule

// ===== hdl/smpd_back.sv =====
// Back part: turns one classified item into its results, one result a cycle unless rsp_ready stalls the output.
module smpd_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  smpd_pkg::item_type head_item,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_action,
   output logic [5:0]         rsp_delivered_signal,
   output logic [1:0]         rsp_old_disposition,
   output logic [31:0]        rsp_old_mask,
   output logic [31:0]        rsp_pending_out,
   output logic [1:0]         rsp_status,
   output logic               rsp_last
);
   import smpd_pkg::*;

   item_type          cur_ff, cur_in;
   logic              busy_ff, busy_in;
   logic              out_valid_ff, out_valid_in;
   logic [1:0]        action_ff, action_in;
   logic [5:0]        sig_ff, sig_in;
   logic              last_ff, last_in;
   logic [1:0]        old_disp_ff;
   logic [MASK_W-1:0] old_mask_ff, pending_ff;
   logic [1:0]        status_ff;
   logic              emit;
   logic [MASK_W-1:0] low_bit;
   logic [5:0]        low_idx;

   assign pop     = !busy_ff && head_valid;
   assign emit    = busy_ff && (!out_valid_ff || rsp_ready);
   assign low_bit = cur_ff.hand & (~cur_ff.hand + MASK_W'(1));

   always_comb begin
      low_idx = '0;
      for (int i = 0; i < MASK_W; i++) begin
         if (low_bit[i]) begin
            low_idx = low_idx | 6'(i);
         end
      end
   end

   always_comb begin
      cur_in       = cur_ff;
      busy_in      = busy_ff;
      action_in    = action_ff;
      sig_in       = sig_ff;
      last_in      = last_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      if (pop) begin
         cur_in  = head_item;
         busy_in = 1'b1;
      end
      if (emit) begin
         out_valid_in = 1'b1;
         if (cur_ff.hand != '0) begin
            action_in   = ACT_HANDLER;
            sig_in      = low_idx;
            last_in     = 1'b0;
            cur_in.hand = cur_ff.hand & ~low_bit;
         end else if (cur_ff.abort_hit) begin
            action_in = ACT_ABORT;
            sig_in    = cur_ff.abort_sig;
            last_in   = 1'b1;
            busy_in   = 1'b0;
         end else begin
            action_in = ACT_STATUS;
            sig_in    = 6'd0;
            last_in   = 1'b1;
            busy_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
      cur_ff    <= cur_in;
      action_ff <= action_in;
      sig_ff    <= sig_in;
      last_ff   <= last_in;
      if (emit) begin
         old_disp_ff <= cur_ff.old_disp;
         old_mask_ff <= cur_ff.old_mask;
         pending_ff  <= cur_ff.pending;
         status_ff   <= cur_ff.status;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_action           = action_ff;
   assign rsp_delivered_signal = sig_ff;
   assign rsp_old_disposition  = old_disp_ff;
   assign rsp_old_mask         = old_mask_ff;
   assign rsp_pending_out      = pending_ff;
   assign rsp_status           = status_ff;
   assign rsp_last             = last_ff;

   a_handler_not_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && action_ff == ACT_HANDLER) |-> (!last_ff && sig_ff != 6'd0))
      else $error("handler result marked last or without a signal");

   a_status_shape: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && action_ff == ACT_STATUS) |-> (last_ff && sig_ff == 6'd0))
      else $error("status result malformed");

   a_final_frees: assert property (@(posedge clock) disable iff (reset)
      (emit && cur_ff.hand == '0) |=> (!busy_ff && out_valid_ff && last_ff))
      else $error("back part still busy after the final result");

endmodule

// ===== hdl/signal_mask_pending_dispatch_core.sv =====
// Top level of the signal mask and pending dispatch block.
//
// An item on the req_ channel (raise, kill, block, unblock, set mask, set
// disposition, query) is classified in the cycle it is accepted: the masks
// and the disposition table are updated at once and the deliveries it causes
// are fixed then. The item then waits in a two-entry queue for the back part.
// The back part emits the results on the rsp_ channel, one per cycle while
// rsp_ready does not stall them: one run-handler result per delivered handler
// signal in rising signal order, then either an abort result or a status-only
// result, which carries last. An accepted item passes through the queue, the
// current-item register and the result register; the back part takes the next
// item once the current one has emitted its last result. Its one-result-per-cycle
// emitter sets the result rate. The front keeps accepting items while the queue
// has room, also while the result register waits on rsp_ready; a stall there
// holds the result and, once the queue fills, deasserts req_ready.
// csr_ writes set the abort signal number and are taken in any cycle.
// Reset clears both masks, sets every disposition to default and the abort
// signal to 6, and empties the queue and the result register.
module signal_mask_pending_dispatch_core #(
   parameter int NUM_SIGNALS = smpd_pkg::NUM_SIG_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_kind,
   input  logic [5:0]  req_signal_number,
   input  logic        req_target_is_self,
   input  logic [31:0] req_mask_value,
   input  logic [1:0]  req_disposition,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_action,
   output logic [5:0]  rsp_delivered_signal,
   output logic [1:0]  rsp_old_disposition,
   output logic [31:0] rsp_old_mask,
   output logic [31:0] rsp_pending_out,
   output logic [1:0]  rsp_status,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [4:0]  csr_abort_signal
);
   import smpd_pkg::*;

   item_type front_item, head_item;
   logic     accept, can_push, pop, head_valid;

   assign req_ready = can_push;
   assign accept    = req_valid && can_push;
   assign csr_ready = 1'b1;

   smpd_front #(
      .NUM_SIGNALS(NUM_SIGNALS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .kind             (req_kind),
      .signal_number    (req_signal_number),
      .target_is_self   (req_target_is_self),
      .mask_value       (req_mask_value),
      .disposition      (req_disposition),
      .csr_write        (csr_valid),
      .csr_abort_signal (csr_abort_signal),
      .item             (front_item)
   );

   smpd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .push_item  (front_item),
      .can_push   (can_push),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   smpd_back u_back (
      .clock                (clock),
      .reset                (reset),
      .head_valid           (head_valid),
      .head_item            (head_item),
      .pop                  (pop),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_action           (rsp_action),
      .rsp_delivered_signal (rsp_delivered_signal),
      .rsp_old_disposition  (rsp_old_disposition),
      .rsp_old_mask         (rsp_old_mask),
      .rsp_pending_out      (rsp_pending_out),
      .rsp_status           (rsp_status),
      .rsp_last             (rsp_last)
   );

endmodule
